FILE: design/apq_pkg.sv
// types, codes and constants shared by the priority queue modules
`default_nettype none

package apq_pkg;

	localparam int unsigned CAPACITY_DEF = 64;

	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_POP    = 3'd1;
	localparam logic [2:0] KIND_CHANGE = 3'd2;
	localparam logic [2:0] KIND_REMOVE = 3'd3;
	localparam logic [2:0] KIND_QUERY  = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_INACTIVE = 2'd3;

	typedef struct packed {
		logic [2:0]         kind;
		logic [5:0]         handle;
		logic signed [31:0] new_priority;
		logic [31:0]        payload;
	} apq_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         out_handle;
		logic [31:0]        out_payload;
		logic               entry_active;
		logic signed [31:0] entry_priority;
		logic [6:0]         entry_count;
	} apq_result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_LAST,
		S_HREAD,
		S_HUSE
	} apq_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_FULL,
		OP_POP,
		OP_EMPTY,
		OP_HIT,
		OP_MISS,
		OP_NOP
	} apq_op_t;

	typedef struct packed {
		logic    load;
		logic    idx_inc;
		logic    scan_rd;
		apq_op_t op;
	} apq_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic idx_last;
		logic best_any;
		logic handle_ok;
	} apq_stat_t;

endpackage

`default_nettype wire

FILE: design/apq_ctrl.sv
// controller state machine of the priority queue
`default_nettype none

module apq_ctrl
	import apq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [2:0] kind,
	input  wire apq_stat_t  stat,
	output logic            busy,
	output apq_cmd_t        cmd
);

	apq_state_t state_q;
	apq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_INSERT: state_d = S_INS;
						KIND_POP: state_d = S_SCAN;
						KIND_CHANGE, KIND_REMOVE, KIND_QUERY: state_d = S_HREAD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS: begin
				if (stat.slot_free || stat.idx_last) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (stat.idx_last) begin
					state_d = S_LAST;
				end
			end
			S_LAST: state_d = S_IDLE;
			S_HREAD: state_d = S_HUSE;
			S_HUSE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (kind)
						KIND_INSERT, KIND_POP, KIND_CHANGE, KIND_REMOVE, KIND_QUERY: cmd.op = OP_NONE;
						default: cmd.op = OP_NOP;
					endcase
				end
			end
			S_INS: begin
				if (stat.slot_free) begin
					cmd.op = OP_INSERT;
				end else if (stat.idx_last) begin
					cmd.op = OP_FULL;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (!stat.idx_last) begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_LAST: cmd.op = stat.best_any ? OP_POP : OP_EMPTY;
			S_HREAD: cmd.op = OP_NONE;
			S_HUSE: cmd.op = stat.handle_ok ? OP_HIT : OP_MISS;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/apq_dp.sv
// datapath of the priority queue: slot store, scan unit and result register
`default_nettype none

module apq_dp
	import apq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire apq_item_t item,
	input  wire apq_cmd_t  cmd,
	output apq_stat_t      stat,
	output logic           done,
	output apq_result_t    result
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	apq_item_t          item_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CAPACITY-1:0] active_q;
	logic [CNT_W-1:0]   count_q;
	logic [63:0]        slot_q [CAPACITY];
	logic [63:0]        rd_q;
	logic               act_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               scan_v_s1;
	logic               best_v_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic signed [31:0] best_prio_q;
	logic [31:0]        best_pay_q;
	logic               done_q;
	apq_result_t        res_q;

	logic [IDX_W-1:0]   h_idx;
	logic               h_ok;
	logic signed [31:0] rd_prio;
	logic [31:0]        rd_pay;
	logic               upd;
	logic [IDX_W-1:0]   nb_idx;
	logic signed [31:0] nb_prio;
	logic [31:0]        nb_pay;
	logic [IDX_W-1:0]   rd_addr;
	apq_result_t        res_d;
	logic [CNT_W-1:0]   cnt_d;
	logic               act_we;
	logic [IDX_W-1:0]   act_addr;
	logic               act_val;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_addr;
	logic [63:0]        mem_wd;
	logic               done_d;

	assign h_idx   = IDX_W'(item_q.handle);
	assign h_ok    = (32'(item_q.handle) < 32'(CAPACITY)) && active_q[h_idx];
	assign rd_prio = $signed(rd_q[63:32]);
	assign rd_pay  = rd_q[31:0];
	assign rd_addr = cmd.scan_rd ? idx_q : h_idx;

	// running maximum, lowest slot wins on equal priority
	assign upd     = scan_v_s1 && act_s1 && (!best_v_q || (rd_prio > best_prio_q));
	assign nb_idx  = upd ? idx_s1 : best_idx_q;
	assign nb_prio = upd ? rd_prio : best_prio_q;
	assign nb_pay  = upd ? rd_pay : best_pay_q;

	assign stat.slot_free = !active_q[idx_q];
	assign stat.idx_last  = (idx_q == IDX_W'(CAPACITY - 1));
	assign stat.best_any  = best_v_q || upd;
	assign stat.handle_ok = h_ok;

	always_comb begin
		res_d = '0;
		res_d.status = STAT_OK;
		cnt_d = count_q;
		act_we = 1'b0;
		act_addr = idx_q;
		act_val = 1'b0;
		mem_we = 1'b0;
		mem_addr = idx_q;
		mem_wd = {item_q.new_priority, item_q.payload};
		case (cmd.op)
			OP_INSERT: begin
				mem_we = 1'b1;
				act_we = 1'b1;
				act_val = 1'b1;
				cnt_d = count_q + CNT_W'(1);
				res_d.out_handle = 6'(idx_q);
			end
			OP_FULL: res_d.status = STAT_FULL;
			OP_POP: begin
				act_we = 1'b1;
				act_addr = nb_idx;
				cnt_d = count_q - CNT_W'(1);
				res_d.out_handle = 6'(nb_idx);
				res_d.out_payload = nb_pay;
				res_d.entry_active = 1'b1;
				res_d.entry_priority = nb_prio;
			end
			OP_EMPTY: res_d.status = STAT_EMPTY;
			OP_HIT: begin
				res_d.entry_active = 1'b1;
				res_d.entry_priority = rd_prio;
				if (item_q.kind == KIND_CHANGE) begin
					mem_we = 1'b1;
					mem_addr = h_idx;
					mem_wd = {item_q.new_priority, rd_pay};
				end
				if (item_q.kind == KIND_REMOVE) begin
					res_d.out_payload = rd_pay;
					act_we = 1'b1;
					act_addr = h_idx;
					cnt_d = count_q - CNT_W'(1);
				end
			end
			OP_MISS: res_d.status = STAT_INACTIVE;
			default: res_d.status = STAT_OK;
		endcase
		res_d.entry_count = 7'(cnt_d);
	end

	assign done_d = (cmd.op != OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			active_q <= '0;
			count_q <= '0;
			scan_v_s1 <= 1'b0;
			best_v_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.load) begin
				best_v_q <= 1'b0;
			end else if (upd) begin
				best_v_q <= 1'b1;
			end
			if (act_we) begin
				active_q[act_addr] <= act_val;
			end
			count_q <= cnt_d;
			scan_v_s1 <= cmd.scan_rd;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		idx_s1 <= idx_q;
		act_s1 <= active_q[idx_q];
		if (upd) begin
			best_idx_q <= idx_s1;
			best_prio_q <= rd_prio;
			best_pay_q <= rd_pay;
		end
		if (done_d) begin
			res_q <= res_d;
		end
	end

	// slot store: priority in the upper half, payload in the lower half
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_q[mem_addr] <= mem_wd;
		end
		rd_q <= slot_q[rd_addr];
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

FILE: design/addressable_max_priority_queue.sv
// top level of the addressable max-priority queue
//
// A word is offered on item with start high; it is taken at a rising edge
// where start is high and busy is low. Each word yields one result word on
// result, shown for exactly one cycle with done high; the receiver cannot
// stall, so it must take the result in that cycle.
// Steps from acceptance to done:
//   insert: one slot a cycle in the search for the lowest free slot
//   pop max: one slot a cycle through the single read port of
//           the slot store plus one compare stage
//   change, remove, query: read of the addressed slot, then the update or report
//   unused kinds: the block stays ready
// busy is high from the acceptance until done rises, so the next word may be
// offered in the cycle that shows the result. No new word is taken while
// an earlier one is still in progress.
// Reset clears every active flag and the entry count at once; stored
// priorities and payloads are only read from active slots.
`default_nettype none

module addressable_max_priority_queue
	import apq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire apq_item_t item,
	output logic           busy,
	output logic           done,
	output apq_result_t    result
);

	apq_cmd_t  cmd;
	apq_stat_t stat;

	apq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	apq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.kind <= KIND_QUERY)) |=> busy)
		else $error("known kind accepted without going busy");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == STAT_EMPTY)) |-> (result.entry_count == 7'd0))
		else $error("empty status with nonzero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.entry_count) <= 32'(CAPACITY)))
		else $error("entry count above capacity");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_addressable_max_priority_queue.sv
// testbench for the addressable max-priority queue: directed and random words checked against a predictor
module tb_addressable_max_priority_queue;
	import apq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = CAPACITY_DEF;
	localparam int RANDOM_WORDS = 900;
	localparam int CYCLE_LIMIT = 600000;

	typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	apq_item_t item;
	logic busy;
	logic done;
	apq_result_t result;

	// queue contents as predicted
	bit live[CAP];
	logic signed [31:0] rank[CAP];
	logic [31:0] cargo[CAP];
	int unsigned live_count;

	apq_item_t pending_words[$];
	apq_result_t due_results[$];

	int offered_words = 0;
	int accepted_words = 0;
	int checked_results = 0;
	int mismatches = 0;
	int burst_left = 0;
	int gap_left = 0;
	int cycles = 0;
	int kind_tally[8];
	int status_tally[4];

	addressable_max_priority_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic apq_item_t make_word(logic [2:0] k, logic [5:0] h,
			logic signed [31:0] p, logic [31:0] d);
		apq_item_t w;
		w.kind = k;
		w.handle = h;
		w.new_priority = p;
		w.payload = d;
		return w;
	endfunction

	// applies one word to the predicted queue and returns the result word it yields
	function automatic apq_result_t queue_apply(apq_item_t w);
		apq_result_t r;
		int slot;
		r = '0;
		slot = -1;
		case (w.kind)
			KIND_INSERT: begin
				for (int i = CAP - 1; i >= 0; i--)
					if (!live[i]) slot = i;
				if (slot < 0) begin
					r.status = STAT_FULL;
				end else begin
					live[slot] = 1'b1;
					rank[slot] = w.new_priority;
					cargo[slot] = w.payload;
					live_count++;
					r.out_handle = 6'(slot);
				end
			end
			KIND_POP: begin
				// strict compare keeps the lowest slot among equal priorities
				for (int i = 0; i < CAP; i++)
					if (live[i] && (slot < 0 || rank[i] > rank[slot])) slot = i;
				if (slot < 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.out_handle = 6'(slot);
					r.out_payload = cargo[slot];
					r.entry_active = 1'b1;
					r.entry_priority = rank[slot];
					live[slot] = 1'b0;
					live_count--;
				end
			end
			KIND_CHANGE, KIND_REMOVE, KIND_QUERY: begin
				if (!live[w.handle]) begin
					r.status = STAT_INACTIVE;
				end else begin
					r.entry_active = 1'b1;
					r.entry_priority = rank[w.handle];
					if (w.kind == KIND_CHANGE) begin
						rank[w.handle] = w.new_priority;
					end else if (w.kind == KIND_REMOVE) begin
						r.out_payload = cargo[w.handle];
						live[w.handle] = 1'b0;
						live_count--;
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_count = 7'(live_count);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %h, want %h",
				checked_results, name, got, want));
	endtask

	function automatic logic signed [31:0] pick_priority();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $urandom();
			default: return 32'(int'($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	function automatic logic [5:0] pick_handle();
		int base;
		base = $urandom_range(0, CAP - 1);
		if (live_count > 0 && $urandom_range(0, 9) < 8)
			for (int i = 0; i < CAP; i++)
				if (live[(base + i) % CAP]) return 6'((base + i) % CAP);
		return 6'($urandom_range(0, 63));
	endfunction

	// driver: new word at the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && accepted_words != offered_words)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_words.size() > 0) begin
				item <= pending_words[0];
				pending_words.delete(0);
				start <= 1'b1;
				offered_words++;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check the result word, then record the word taken at this edge
	always @(posedge clk) begin
		apq_result_t want;
		if (arst_n) begin
			if (done) begin
				if (due_results.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = due_results[0];
					due_results.delete(0);
					check_field("status", 32'(result.status), 32'(want.status));
					check_field("out_handle", 32'(result.out_handle), 32'(want.out_handle));
					check_field("out_payload", result.out_payload, want.out_payload);
					check_field("entry_active", 32'(result.entry_active),
						32'(want.entry_active));
					check_field("entry_priority", result.entry_priority, want.entry_priority);
					check_field("entry_count", 32'(result.entry_count), 32'(want.entry_count));
					status_tally[want.status]++;
				end
				checked_results++;
			end
			if (start && !busy) begin
				due_results.push_back(queue_apply(item));
				kind_tally[item.kind]++;
				accepted_words++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, due_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int made;
		int seg_left;
		int phase;
		int roll;
		mode_t mode;
		logic [2:0] k;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		live_count = 0;
		for (int i = 0; i < CAP; i++) live[i] = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty queue, extremes, ties, reuse of freed slots, unused kinds
		pending_words.push_back(make_word(KIND_QUERY, 6'd0, 32'sd0, 32'd0));
		pending_words.push_back(make_word(KIND_POP, 6'd0, 32'sd0, 32'd0));
		pending_words.push_back(make_word(KIND_CHANGE, 6'd5, 32'sd7, 32'd0));
		pending_words.push_back(make_word(KIND_REMOVE, 6'd63, 32'sd0, 32'hffffffff));
		pending_words.push_back(make_word(KIND_INSERT, 6'd63, 32'sh7fffffff, 32'hffffffff));
		pending_words.push_back(make_word(KIND_INSERT, 6'd0, 32'sh80000000, 32'h00000000));
		pending_words.push_back(make_word(KIND_INSERT, 6'd0, 32'sh7fffffff, 32'ha5a5a5a5));
		pending_words.push_back(make_word(KIND_INSERT, 6'd0, -32'sd1, 32'h5a5a5a5a));
		pending_words.push_back(make_word(KIND_QUERY, 6'd2, 32'sd0, 32'd0));
		pending_words.push_back(make_word(KIND_CHANGE, 6'd3, -32'sd1, 32'd0));
		pending_words.push_back(make_word(KIND_CHANGE, 6'd1, 32'sh7fffffff, 32'd0));
		pending_words.push_back(make_word(KIND_POP, 6'd0, 32'sd0, 32'd0));
		pending_words.push_back(make_word(KIND_INSERT, 6'd0, 32'sd0, 32'h12345678));
		pending_words.push_back(make_word(KIND_REMOVE, 6'd2, 32'sd0, 32'd0));
		pending_words.push_back(make_word(KIND_REMOVE, 6'd2, 32'sd0, 32'd0));
		for (int i = 1; i <= 3; i++)
			pending_words.push_back(make_word(3'(KIND_QUERY + i), 6'($urandom()),
				$urandom(), $urandom()));
		repeat (4) pending_words.push_back(make_word(KIND_POP, 6'd0, 32'sd0, 32'd0));

		// random part: fill, mix and drain phases with random content
		made = 0;
		phase = 0;
		seg_left = 0;
		mode = MODE_FILL;
		while (made < RANDOM_WORDS) begin
			while (pending_words.size() >= 2) begin
				@(posedge clk);
				#2;
			end
			if (seg_left == 0) begin
				case (phase % 4)
					0: begin
						mode = MODE_FILL;
						seg_left = $urandom_range(70, 130);
					end
					2: begin
						mode = MODE_DRAIN;
						seg_left = $urandom_range(60, 120);
					end
					default: begin
						mode = MODE_MIX;
						seg_left = $urandom_range(40, 100);
					end
				endcase
				phase++;
			end
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 49) == 0) begin
				pending_words.push_back(make_word(3'(KIND_QUERY + $urandom_range(1, 3)),
					6'($urandom()), $urandom(), $urandom()));
				continue;
			end
			case (mode)
				MODE_FILL: k = (roll < 88) ? KIND_INSERT : (roll < 92) ? KIND_QUERY :
					(roll < 96) ? KIND_CHANGE : KIND_POP;
				MODE_DRAIN: k = (roll < 45) ? KIND_POP : (roll < 80) ? KIND_REMOVE :
					(roll < 88) ? KIND_CHANGE : (roll < 94) ? KIND_QUERY : KIND_INSERT;
				default: k = (roll < 35) ? KIND_INSERT : (roll < 55) ? KIND_POP :
					(roll < 70) ? KIND_CHANGE : (roll < 85) ? KIND_REMOVE : KIND_QUERY;
			endcase
			pending_words.push_back(make_word(k, pick_handle(), pick_priority(), $urandom()));
			made++;
			seg_left--;
		end

		while (pending_words.size() > 0 || accepted_words != offered_words) @(posedge clk);
		while (due_results.size() > 0) @(posedge clk);
		repeat (CAP + 4) @(posedge clk);

		$display("covered %0d words: %0d insert, %0d pop, %0d change, %0d remove, %0d query",
			accepted_words, kind_tally[KIND_INSERT], kind_tally[KIND_POP],
			kind_tally[KIND_CHANGE], kind_tally[KIND_REMOVE], kind_tally[KIND_QUERY]);
		$display("%0d results checked: %0d ok, %0d empty, %0d full, %0d inactive handle",
			checked_results, status_tally[STAT_OK], status_tally[STAT_EMPTY],
			status_tally[STAT_FULL], status_tally[STAT_INACTIVE]);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/apq_pkg.sv
design/apq_ctrl.sv
design/apq_dp.sv
design/addressable_max_priority_queue.sv
verif/tb_addressable_max_priority_queue.sv
